/* rtl/core/unitized_table_build_reduce_unit_defines.svh */
// Assertion macros for the unitized table build and reduce unit
`ifndef UNITIZED_TABLE_BUILD_REDUCE_UNIT_DEFINES_SVH
`define UNITIZED_TABLE_BUILD_REDUCE_UNIT_DEFINES_SVH

// check expr at every edge out of reset
`define UTBR_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// check cons in the cycle after ante
`define UTBR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/utbr_pkg.sv */
// Shared constants, types and functions of the unitized table unit
`default_nettype none
package utbr_pkg;
	localparam int MAX_VARS = 5;
	localparam int MAX_COLS = 2 * MAX_VARS + 2;
	localparam int MAX_ROWS = 1 << MAX_VARS;
	localparam int ROW_W = MAX_COLS;
	localparam int CNT_W = MAX_VARS + 1;
	localparam int COL_W = $clog2(MAX_COLS + 1);
	localparam int VAR_W = 3;
	localparam int ID_W = 6;

	localparam logic [ID_W-1:0] ID_NEG_BASE = 6'd31;
	localparam logic [ID_W-1:0] ID_ZERO = 6'd62;
	localparam logic [ID_W-1:0] ID_ONE = 6'd63;

	localparam logic REG_VAR_COUNT = 1'b0;

	typedef enum logic [1:0] {
		KIND_ROW = 2'd0,
		KIND_COL = 2'd1,
		KIND_ERR = 2'd2
	} kind_t;

	typedef struct packed {
		logic inc;
		logic clr;
	} ones_ctl_t;

	function automatic logic [VAR_W-1:0] eff_vars(input logic [VAR_W-1:0] v);
		if (v == '0) begin
			return 3'd1;
		end
		if (v > 3'(MAX_VARS)) begin
			return 3'(MAX_VARS);
		end
		return v;
	endfunction

	function automatic logic [ID_W-1:0] col_id(input logic [COL_W-1:0] c,
		input logic [VAR_W-1:0] n);
		logic [COL_W-1:0] n1;
		logic [COL_W-1:0] n2;
		n1 = COL_W'(n);
		n2 = COL_W'({n, 1'b0});
		if (c < n1) begin
			return ID_W'(c);
		end else if (c < n2) begin
			return ID_NEG_BASE + ID_W'(c - n1);
		end else if (c == n2) begin
			return ID_ZERO;
		end
		return ID_ONE;
	endfunction
endpackage
`default_nettype wire

/* rtl/core/utbr_ones.sv */
// Per-column ones counters of the unitized table
`default_nettype none
module utbr_ones (
	input  logic                             clk,
	input  logic                             arst_n,
	input  utbr_pkg::ones_ctl_t              ctl,
	input  logic [utbr_pkg::ROW_W-1:0]       row,
	input  logic [utbr_pkg::COL_W-1:0]       rd_idx,
	output logic [utbr_pkg::CNT_W-1:0]       count
);
	import utbr_pkg::*;

	logic [CNT_W-1:0] ones_q [MAX_COLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < MAX_COLS; c++) begin
				ones_q[c] <= '0;
			end
		end else if (ctl.clr) begin
			for (int c = 0; c < MAX_COLS; c++) begin
				ones_q[c] <= '0;
			end
		end else if (ctl.inc) begin
			for (int c = 0; c < MAX_COLS; c++) begin
				ones_q[c] <= ones_q[c] + CNT_W'(row[c]);
			end
		end
	end

	assign count = (rd_idx < COL_W'(MAX_COLS)) ? ones_q[rd_idx] : '0;
endmodule
`default_nettype wire

/* rtl/core/unitized_table_build_reduce_unit.sv */
// Top level: loads truth-table words, reduces the unitized table, emits rows and column ids
// Load: one truth-table word per cycle, s_tready high while loading.
// Reduction: a sequencer over one row memory with separate read and write ports, one row
// pair per cycle for the dominance and essential-column passes, one column per cycle for
// column scans. Emission: each row is read, latched, compacted bit by bit and handed off;
// each kept column is handed off and each dropped column passed over; m_tready low stalls.
// Reset clears var_count to 3 and all counts; the row memory holds no reset value.
`default_nettype none
`include "unitized_table_build_reduce_unit_defines.svh"
module unitized_table_build_reduce_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] func_bit, [1] care_bit
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [4:0] item_index, [16:5] row_bits, [22:17] column_id
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast
);
	import utbr_pkg::*;

	typedef enum logic [4:0] {
		ST_LOAD, ST_ERRW, ST_BEST,
		ST_RC_INIT, ST_RC_RDJ, ST_RC_LDJ, ST_RC_CHK, ST_RC_SCAN, ST_RC_FIN,
		ST_RR_INIT, ST_RR_RDI, ST_RR_LDI, ST_RR_CHK, ST_RR_DEC, ST_RR_CRD, ST_RR_CWR,
		ST_RR_FIN,
		ST_EM_RD, ST_EM_LAT, ST_EM_BIT, ST_EM_ROWW, ST_EM_COL, ST_EM_COLW
	} state_t;

	typedef enum logic [1:0] {
		P_RC0, P_RR1, P_RC, P_RR
	} phase_t;

	localparam int RA_W = $clog2(MAX_ROWS);

	state_t           state_q;
	phase_t           phase_q;
	logic [VAR_W-1:0] var_count_q;
	logic [CNT_W-1:0] pos_q, rt_q, best_q;
	logic [VAR_W-1:0] n_b_q;
	logic [ROW_W-1:0] live_q, ess_q, rem_q, mask_q;
	logic [COL_W-1:0] ctot_q, ess_cnt_q, rem_cnt_q, start_q, iter_q, c_q, q_q, save_q;
	logic             save_vld_q, chg_q;
	logic [CNT_W-1:0] i_q, j_q, k_q;
	logic [ROW_W-1:0] a_q, row_q, cmp_q, rd_q;
	logic [MAX_ROWS-1:0] drop_q;
	kind_t            out_kind_q;
	logic [4:0]       out_idx_q;
	logic [ROW_W-1:0] out_row_q;
	logic [ID_W-1:0]  out_id_q;
	logic             out_vld_q, out_last_q;

	logic [ROW_W-1:0] rows_mem [MAX_ROWS];

	// configuration port
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_VAR_COUNT);
	assign prdata = (paddr[2] == REG_VAR_COUNT) ? {29'd0, var_count_q} : '0;

	// load path
	logic             acc, ld_wr, ld_last;
	logic [VAR_W-1:0] n_ld;
	logic [CNT_W-1:0] limit, rt_nx;
	logic [COL_W-1:0] nc0;
	logic [ROW_W-1:0] row_ld;

	assign s_tready = (state_q == ST_LOAD);
	assign acc = s_tvalid & s_tready;
	assign n_ld = eff_vars(var_count_q);
	assign limit = CNT_W'(1) << n_ld;
	assign ld_wr = acc & s_tdata[1] & (pos_q < limit) & (rt_q < CNT_W'(MAX_ROWS));
	assign ld_last = acc & s_tlast;
	assign rt_nx = rt_q + CNT_W'(ld_wr);
	assign nc0 = COL_W'({n_ld, 1'b0}) + COL_W'(2);

	always_comb begin
		logic [COL_W-1:0] col;
		col = '0;
		row_ld = '0;
		for (int j = 0; j < MAX_VARS; j++) begin
			if (3'(j) < n_ld) begin
				col = (pos_q[j] == s_tdata[0]) ? COL_W'(j) : COL_W'(j) + COL_W'(n_ld);
				row_ld[col] = 1'b1;
			end
		end
		row_ld[COL_W'({n_ld, 1'b0}) + COL_W'(s_tdata[0])] = 1'b1;
	end

	// ones counters
	ones_ctl_t        ones_ctl;
	logic [CNT_W-1:0] ones_rd;
	logic             run_done;

	assign run_done = m_tvalid & m_tready & m_tlast;
	assign ones_ctl.inc = ld_wr;
	assign ones_ctl.clr = run_done;

	utbr_ones u_ones (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ones_ctl),
		.row    (row_ld),
		.rd_idx (c_q),
		.count  (ones_rd)
	);

	// best column scan
	logic             b_gt, b_end;
	logic [CNT_W-1:0] best_nx;
	logic [COL_W-1:0] save_nx;
	assign b_gt = ones_rd > best_q;
	assign best_nx = b_gt ? ones_rd : best_q;
	assign save_nx = b_gt ? c_q : save_q;
	assign b_end = (c_q + COL_W'(1)) == ctot_q;

	// column reduction
	logic             keep, one_rc, hit_rc, rc_k_more, rc_j_more, iter_go, pair_go;
	logic [ROW_W-1:0] x_rc;
	logic [COL_W-1:0] ess_cnt_nx;
	logic [4:0]       sel_rc, sel_sc;
	logic             sc_end, sc_pick;

	assign keep = (phase_q == P_RC0) && save_vld_q;
	assign x_rc = a_q & rd_q & mask_q & live_q;
	assign one_rc = $countones(x_rc) == 1;
	assign ess_cnt_nx = ess_cnt_q + COL_W'(one_rc && ((ess_q & x_rc) == '0));
	assign sel_rc = 5'(rem_cnt_q) + 5'(ess_cnt_nx) + 5'(keep);
	assign hit_rc = one_rc && (sel_rc == 5'(ctot_q));
	assign rc_k_more = (k_q + CNT_W'(1)) < rt_q;
	assign rc_j_more = (j_q + CNT_W'(2)) < rt_q;
	assign iter_go = (5'(iter_q) + 5'd2) < 5'(ctot_q);
	assign pair_go = rt_q >= CNT_W'(2);
	assign sc_end = (c_q == COL_W'(MAX_COLS));
	assign sc_pick = !sc_end && live_q[c_q] && !(keep && (c_q == save_q)) && !ess_q[c_q];
	assign sel_sc = 5'(rem_cnt_q) + 5'd1 + 5'(ess_cnt_q) + 5'(keep);

	// row reduction
	logic [ROW_W-1:0] b_rr, u_rr;
	logic             rr_brk, rr_dj, rr_j_more, rr_i_more, rr_keep;
	assign b_rr = rd_q & live_q;
	assign u_rr = a_q | b_rr;
	assign rr_brk = (a_q == b_rr) || (u_rr == a_q);
	assign rr_dj = !rr_brk && (u_rr == b_rr);
	assign rr_j_more = (j_q + CNT_W'(1)) < rt_q;
	assign rr_i_more = (i_q + CNT_W'(2)) < rt_q;
	assign rr_keep = !drop_q[i_q[RA_W-1:0]];

	// emission compaction
	logic [ROW_W-1:0] cmp_nx;
	always_comb begin
		cmp_nx = cmp_q;
		if (live_q[c_q]) begin
			cmp_nx[q_q] = row_q[c_q];
		end
	end

	// memory ports
	logic             mem_we;
	logic [RA_W-1:0]  mem_waddr, mem_raddr;
	logic [ROW_W-1:0] mem_wdata;

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = rt_q[RA_W-1:0];
		mem_wdata = row_ld;
		mem_raddr = '0;
		case (state_q)
			ST_LOAD: begin
				mem_we = ld_wr;
			end
			ST_RC_RDJ: mem_raddr = j_q[RA_W-1:0];
			ST_RC_LDJ: mem_raddr = RA_W'(j_q + CNT_W'(1));
			ST_RC_CHK: begin
				mem_raddr = rc_k_more ? RA_W'(k_q + CNT_W'(1)) : RA_W'(j_q + CNT_W'(1));
			end
			ST_RR_RDI: mem_raddr = i_q[RA_W-1:0];
			ST_RR_LDI: mem_raddr = RA_W'(i_q + CNT_W'(1));
			ST_RR_CHK: begin
				mem_raddr = (!rr_brk && rr_j_more) ? RA_W'(j_q + CNT_W'(1)) :
					RA_W'(i_q + CNT_W'(1));
			end
			ST_RR_CRD: mem_raddr = i_q[RA_W-1:0];
			ST_RR_CWR: begin
				mem_we = rr_keep;
				mem_waddr = k_q[RA_W-1:0];
				mem_wdata = rd_q;
				mem_raddr = RA_W'(i_q + CNT_W'(1));
			end
			ST_EM_RD: mem_raddr = i_q[RA_W-1:0];
			default: mem_raddr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			rows_mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= rows_mem[mem_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			phase_q <= P_RC0;
			var_count_q <= 3'd3;
			pos_q <= '0;
			rt_q <= '0;
			best_q <= '0;
			n_b_q <= '0;
			live_q <= '0;
			ess_q <= '0;
			rem_q <= '0;
			mask_q <= '0;
			ctot_q <= '0;
			ess_cnt_q <= '0;
			rem_cnt_q <= '0;
			start_q <= '0;
			iter_q <= '0;
			c_q <= '0;
			q_q <= '0;
			save_q <= '0;
			save_vld_q <= 1'b0;
			chg_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			a_q <= '0;
			row_q <= '0;
			cmp_q <= '0;
			drop_q <= '0;
			out_kind_q <= KIND_ROW;
			out_idx_q <= '0;
			out_row_q <= '0;
			out_id_q <= '0;
			out_vld_q <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				var_count_q <= pwdata[VAR_W-1:0];
			end
			case (state_q)
				ST_LOAD: begin
					if (acc) begin
						rt_q <= rt_nx;
						if (pos_q < limit) begin
							pos_q <= pos_q + CNT_W'(1);
						end
						if (ld_last) begin
							if (rt_nx == '0) begin
								out_kind_q <= KIND_ERR;
								out_idx_q <= '0;
								out_row_q <= '0;
								out_id_q <= '0;
								out_last_q <= 1'b1;
								out_vld_q <= 1'b1;
								state_q <= ST_ERRW;
							end else begin
								n_b_q <= n_ld;
								live_q <= ~({ROW_W{1'b1}} << nc0);
								ctot_q <= nc0;
								best_q <= rt_nx >> 1;
								save_vld_q <= 1'b0;
								save_q <= '0;
								c_q <= '0;
								state_q <= ST_BEST;
							end
						end
					end
				end
				ST_ERRW: begin
					if (m_tready) begin
						out_vld_q <= 1'b0;
						rt_q <= '0;
						pos_q <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_BEST: begin
					best_q <= best_nx;
					save_q <= save_nx;
					save_vld_q <= save_vld_q | b_gt;
					c_q <= c_q + COL_W'(1);
					if (b_end) begin
						if (best_nx == rt_q) begin
							live_q <= ROW_W'(1) << save_nx;
							ctot_q <= COL_W'(1);
							phase_q <= P_RR1;
							state_q <= ST_RR_INIT;
						end else begin
							phase_q <= P_RC0;
							state_q <= ST_RC_INIT;
						end
					end
				end
				ST_RC_INIT: begin
					ess_q <= '0;
					rem_q <= '0;
					mask_q <= '1;
					ess_cnt_q <= '0;
					rem_cnt_q <= '0;
					start_q <= '0;
					iter_q <= '0;
					if (ctot_q == COL_W'(1) || ctot_q == COL_W'(3) || ctot_q < COL_W'(2)) begin
						state_q <= ST_RC_FIN;
					end else if (pair_go) begin
						j_q <= '0;
						state_q <= ST_RC_RDJ;
					end else begin
						c_q <= '0;
						state_q <= ST_RC_SCAN;
					end
				end
				ST_RC_RDJ: begin
					state_q <= ST_RC_LDJ;
				end
				ST_RC_LDJ: begin
					a_q <= rd_q & live_q;
					k_q <= j_q + CNT_W'(1);
					state_q <= ST_RC_CHK;
				end
				ST_RC_CHK: begin
					if (one_rc) begin
						ess_q <= ess_q | x_rc;
					end
					ess_cnt_q <= ess_cnt_nx;
					if (hit_rc) begin
						state_q <= ST_RC_FIN;
					end else if (rc_k_more) begin
						k_q <= k_q + CNT_W'(1);
					end else if (rc_j_more) begin
						j_q <= j_q + CNT_W'(1);
						state_q <= ST_RC_LDJ;
					end else begin
						c_q <= start_q;
						state_q <= ST_RC_SCAN;
					end
				end
				ST_RC_SCAN: begin
					if (sc_end || sc_pick) begin
						if (sc_pick) begin
							rem_q <= rem_q | (ROW_W'(1) << c_q);
							rem_cnt_q <= rem_cnt_q + COL_W'(1);
							start_q <= c_q + COL_W'(1);
							mask_q <= mask_q & ~(ROW_W'(1) << c_q);
						end
						if (sc_pick && sel_sc == 5'(ctot_q)) begin
							state_q <= ST_RC_FIN;
						end else if (!iter_go) begin
							state_q <= ST_RC_FIN;
						end else if (pair_go) begin
							iter_q <= iter_q + COL_W'(1);
							j_q <= '0;
							state_q <= ST_RC_RDJ;
						end else begin
							iter_q <= iter_q + COL_W'(1);
							c_q <= sc_pick ? c_q + COL_W'(1) : start_q;
						end
					end else begin
						c_q <= c_q + COL_W'(1);
					end
				end
				ST_RC_FIN: begin
					live_q <= live_q & ~rem_q;
					ctot_q <= ctot_q - rem_cnt_q;
					i_q <= '0;
					case (phase_q)
						P_RC0: begin
							phase_q <= P_RR1;
							state_q <= ST_RR_INIT;
						end
						default: begin
							if (rem_q != '0) begin
								phase_q <= P_RR;
								state_q <= ST_RR_INIT;
							end else begin
								state_q <= ST_EM_RD;
							end
						end
					endcase
				end
				ST_RR_INIT: begin
					drop_q <= '0;
					i_q <= '0;
					if (ctot_q == COL_W'(1) || ctot_q == COL_W'(3) || !pair_go) begin
						state_q <= ST_RR_DEC;
					end else begin
						state_q <= ST_RR_RDI;
					end
				end
				ST_RR_RDI: begin
					state_q <= ST_RR_LDI;
				end
				ST_RR_LDI: begin
					a_q <= rd_q & live_q;
					j_q <= i_q + CNT_W'(1);
					state_q <= ST_RR_CHK;
				end
				ST_RR_CHK: begin
					if (rr_brk) begin
						drop_q[i_q[RA_W-1:0]] <= 1'b1;
					end
					if (rr_dj) begin
						drop_q[j_q[RA_W-1:0]] <= 1'b1;
					end
					if (!rr_brk && rr_j_more) begin
						j_q <= j_q + CNT_W'(1);
					end else if (rr_i_more) begin
						i_q <= i_q + CNT_W'(1);
						state_q <= ST_RR_LDI;
					end else begin
						state_q <= ST_RR_DEC;
					end
				end
				ST_RR_DEC: begin
					i_q <= '0;
					k_q <= '0;
					if (drop_q == '0) begin
						chg_q <= 1'b0;
						state_q <= ST_RR_FIN;
					end else begin
						state_q <= ST_RR_CRD;
					end
				end
				ST_RR_CRD: begin
					state_q <= ST_RR_CWR;
				end
				ST_RR_CWR: begin
					k_q <= k_q + CNT_W'(rr_keep);
					if ((i_q + CNT_W'(1)) < rt_q) begin
						i_q <= i_q + CNT_W'(1);
					end else begin
						rt_q <= k_q + CNT_W'(rr_keep);
						chg_q <= 1'b1;
						state_q <= ST_RR_FIN;
					end
				end
				ST_RR_FIN: begin
					i_q <= '0;
					case (phase_q)
						P_RR1: begin
							phase_q <= P_RC;
							state_q <= ST_RC_INIT;
						end
						default: begin
							if (chg_q) begin
								phase_q <= P_RC;
								state_q <= ST_RC_INIT;
							end else begin
								state_q <= ST_EM_RD;
							end
						end
					endcase
				end
				ST_EM_RD: begin
					state_q <= ST_EM_LAT;
				end
				ST_EM_LAT: begin
					row_q <= rd_q;
					c_q <= '0;
					q_q <= '0;
					cmp_q <= '0;
					state_q <= ST_EM_BIT;
				end
				ST_EM_BIT: begin
					cmp_q <= cmp_nx;
					q_q <= q_q + COL_W'(live_q[c_q]);
					c_q <= c_q + COL_W'(1);
					if (c_q == COL_W'(MAX_COLS - 1)) begin
						out_kind_q <= KIND_ROW;
						out_idx_q <= i_q[4:0];
						out_row_q <= cmp_nx;
						out_id_q <= '0;
						out_last_q <= 1'b0;
						out_vld_q <= 1'b1;
						state_q <= ST_EM_ROWW;
					end
				end
				ST_EM_ROWW: begin
					if (m_tready) begin
						out_vld_q <= 1'b0;
						if ((i_q + CNT_W'(1)) < rt_q) begin
							i_q <= i_q + CNT_W'(1);
							state_q <= ST_EM_RD;
						end else begin
							c_q <= '0;
							k_q <= '0;
							state_q <= ST_EM_COL;
						end
					end
				end
				ST_EM_COL: begin
					if (!sc_end && live_q[c_q]) begin
						out_kind_q <= KIND_COL;
						out_idx_q <= k_q[4:0];
						out_row_q <= '0;
						out_id_q <= col_id(c_q, n_b_q);
						out_last_q <= (k_q == CNT_W'(ctot_q - COL_W'(1)));
						out_vld_q <= 1'b1;
						state_q <= ST_EM_COLW;
					end else begin
						c_q <= c_q + COL_W'(1);
					end
				end
				ST_EM_COLW: begin
					if (m_tready) begin
						out_vld_q <= 1'b0;
						k_q <= k_q + CNT_W'(1);
						c_q <= c_q + COL_W'(1);
						if (out_last_q) begin
							rt_q <= '0;
							pos_q <= '0;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_EM_COL;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = {1'b0, out_id_q, out_row_q, out_idx_q};
	assign m_tuser = out_kind_q;
	assign m_tlast = out_last_q;

	`UTBR_ASSERT_ALWAYS(a_one_side, !(s_tready && m_tvalid), "load and emit overlap")
	`UTBR_ASSERT_ALWAYS(a_col_total, $countones(live_q) == int'(ctot_q), "column count off")
	`UTBR_ASSERT_NEXT(a_reload, run_done, s_tready, "no return to load after run")
endmodule
`default_nettype wire

/* bench/unitized_table_build_reduce_unit_tb.sv */
// Self-checking bench for the unitized table build and reduce unit
`timescale 1ns / 100ps
`default_nettype none
module unitized_table_build_reduce_unit_tb;
	import utbr_pkg::*;

	typedef struct {
		kind_t    kind;
		bit [4:0] index;
		bit [11:0] row;
		bit [5:0] id;
		bit       last;
	} table_word_t;

	class table_scoreboard;
		bit [2:0] var_reg;
		int rows[MAX_ROWS];
		int ids[MAX_COLS];
		int ones[MAX_COLS];
		int n_rows;
		int n_cols;
		int pos;
		table_word_t pending_q[$];
		int errors;
		int checked;
		int runs;

		function new();
			var_reg = 3'd3;
			n_rows = 0;
			n_cols = 0;
			pos = 0;
			errors = 0;
			checked = 0;
			runs = 0;
			foreach (ones[i]) ones[i] = 0;
		endfunction

		function int vars_used();
			if (var_reg == 0) return 1;
			if (var_reg > MAX_VARS) return MAX_VARS;
			return var_reg;
		endfunction

		function bit one_bit(int x, int nc, output int p);
			bit seen;
			seen = 0;
			p = 0;
			for (int c = 0; c < nc; c++) begin
				if (x[c]) begin
					if (seen) return 0;
					p = c;
					seen = 1;
				end
			end
			return seen;
		endfunction

		function void compact_columns(int drop);
			int k;
			int nv;
			int q;
			for (int r = 0; r < n_rows; r++) begin
				nv = 0;
				q = 0;
				for (int c = 0; c < n_cols; c++) begin
					if (drop[c]) continue;
					if (rows[r][c]) nv |= 1 << q;
					q++;
				end
				rows[r] = nv;
			end
			k = 0;
			for (int c = 0; c < n_cols; c++) begin
				if (drop[c]) continue;
				ids[k] = ids[c];
				k++;
			end
			n_cols = k;
		endfunction

		function bit drop_dominated_rows();
			longint unsigned drop;
			int a;
			int b;
			int u;
			int k;
			drop = 0;
			if (n_cols == 1 || n_cols == 3) return 0;
			for (int i = 0; i < n_rows; i++) begin
				for (int j = i + 1; j < n_rows; j++) begin
					a = rows[i];
					b = rows[j];
					u = a | b;
					if (a == b || u == a) begin
						drop[i] = 1'b1;
						break;
					end
					if (u == b) drop[j] = 1'b1;
				end
			end
			if (drop == 0) return 0;
			k = 0;
			for (int i = 0; i < n_rows; i++) begin
				if (!drop[i]) begin
					rows[k] = rows[i];
					k++;
				end
			end
			n_rows = k;
			return 1;
		endfunction

		function bit drop_free_columns(int save);
			int nc;
			int keep_one;
			int ess;
			int rem;
			int mask;
			int start;
			int d;
			int sel;
			int x;
			bit may;
			nc = n_cols;
			ess = 0;
			rem = 0;
			mask = -1;
			start = 0;
			may = 1;
			if (nc == 1 || nc == 3) return 0;
			keep_one = (save < nc) ? 1 : 0;
			for (int i = 0; i + 1 < nc; i++) begin
				for (int j = 0; j < n_rows && may; j++) begin
					for (int k = j + 1; k < n_rows; k++) begin
						x = rows[j] & rows[k] & mask;
						if (one_bit(x, nc, d)) begin
							ess |= 1 << d;
							sel = $countones(rem) + $countones(ess) + keep_one;
							if (sel == nc) begin
								may = 0;
								break;
							end
						end
					end
				end
				if (!may) break;
				for (int j = start; j < nc; j++) begin
					if (j == save) continue;
					if (!ess[j]) begin
						rem |= 1 << j;
						start = j + 1;
						sel = $countones(rem) + $countones(ess) + keep_one;
						if (sel == nc) begin
							compact_columns(rem);
							return 1;
						end
						mask &= ~(1 << j);
						break;
					end
				end
			end
			compact_columns(rem);
			return rem != 0;
		endfunction

		function void reduce_table();
			int n;
			int nc;
			int best;
			int save;
			n = vars_used();
			nc = 2 * n + 2;
			save = 64;
			for (int i = 0; i < n; i++) begin
				ids[i] = i;
				ids[n + i] = 31 + i;
			end
			ids[2 * n] = 62;
			ids[2 * n + 1] = 63;
			n_cols = nc;
			for (int i = 0; i < n_rows; i++) rows[i] &= (1 << nc) - 1;
			best = n_rows / 2;
			for (int i = 0; i < nc; i++) begin
				if (ones[i] > best) begin
					save = i;
					best = ones[i];
				end
			end
			if (best == n_rows) begin
				compact_columns(((1 << nc) - 1) & ~(1 << save));
			end else begin
				void'(drop_free_columns(save));
			end
			void'(drop_dominated_rows());
			if (!drop_free_columns(64)) return;
			forever begin
				if (!drop_dominated_rows()) return;
				if (!drop_free_columns(64)) return;
			end
		endfunction

		function void note_word(bit func, bit care, bit last);
			int n;
			int lim;
			int row;
			int col;
			table_word_t w;
			n = vars_used();
			lim = 1 << n;
			if (care && pos < lim && n_rows < MAX_ROWS) begin
				row = 0;
				for (int j = 0; j < n; j++) begin
					col = (pos[j] == func) ? j : j + n;
					row |= 1 << col;
					ones[col]++;
				end
				col = func ? 2 * n + 1 : 2 * n;
				row |= 1 << col;
				ones[col]++;
				rows[n_rows] = row;
				n_rows++;
			end
			if (pos < lim) pos++;
			if (!last) return;
			runs++;
			if (n_rows == 0) begin
				w = '{KIND_ERR, 5'd0, 12'd0, 6'd0, 1'b1};
				pending_q = {pending_q, w};
			end else begin
				reduce_table();
				for (int i = 0; i < n_rows; i++) begin
					w = '{KIND_ROW, 5'(i), 12'(rows[i]), 6'd0, 1'b0};
					pending_q = {pending_q, w};
				end
				for (int i = 0; i < n_cols; i++) begin
					w = '{KIND_COL, 5'(i), 12'd0, 6'(ids[i]), 1'b0};
					pending_q = {pending_q, w};
				end
				pending_q[pending_q.size() - 1].last = 1'b1;
			end
			n_rows = 0;
			pos = 0;
			foreach (ones[i]) ones[i] = 0;
		endfunction

		function void check_word(bit [1:0] kind, bit [4:0] index, bit [11:0] row,
			bit [5:0] id, bit last);
			table_word_t e;
			if (pending_q.size() == 0) begin
				$error("unexpected output word kind=%0d index=%0d", kind, index);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			checked++;
			if (kind != e.kind) begin
				$error("kind: expected %0d, got %0d", e.kind, kind);
				errors++;
			end
			if (index != e.index) begin
				$error("item_index: expected %0d, got %0d", e.index, index);
				errors++;
			end
			if (row != e.row) begin
				$error("row_bits: expected %h, got %h", e.row, row);
				errors++;
			end
			if (id != e.id) begin
				$error("column_id: expected %0d, got %0d", e.id, id);
				errors++;
			end
			if (last != e.last) begin
				$error("is_last: expected %0d, got %0d", e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	table_scoreboard sb;
	int send_idle;
	int recv_idle;
	int hold_cycles;
	int sent;

	unitized_table_build_reduce_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	initial begin
		sb = new();
		send_idle = 24;
		recv_idle = 72;
		hold_cycles = 0;
		sent = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
	end

	always begin
		@(posedge clk);
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_word(m_tuser, m_tdata[4:0], m_tdata[16:5], m_tdata[22:17], m_tlast);
		end
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic write_var_count(bit [2:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 3'(4 * REG_VAR_COUNT);
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.var_reg = value;
	endtask

	task automatic drain();
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic send_word(bit func, bit care, bit last);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, care, func};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_word(func, care, last);
		sent++;
	endtask

	task automatic send_run(int len, int care_pct, int func_mode);
		bit f;
		for (int i = 0; i < len; i++) begin
			f = (func_mode == 2) ? 1'($urandom_range(1)) : 1'(func_mode);
			send_word(f, $urandom_range(99) < care_pct, i == len - 1);
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int nv;
		int eff;
		int len;
		bit [2:0] cfg;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		// directed: defaults, the smallest counts, error run, overflow, constants
		send_run(8, 100, 2);
		drain();
		write_var_count(3'd1);
		send_run(2, 100, 2);
		send_run(2, 0, 2);
		send_run(4, 100, 2);
		drain();
		write_var_count(3'd0);
		send_run(2, 100, 1);
		send_run(2, 100, 0);
		send_run(1, 100, 2);
		drain();
		write_var_count(3'd2);
		send_run(4, 100, 2);
		drain();
		while (sent < 460) begin
			if (sent >= 340) begin
				send_idle = 0;
				recv_idle = 0;
			end else if (sent >= 180) begin
				send_idle = 72;
				recv_idle = 24;
			end
			if (sent >= 120 && sent < 135 && hold_cycles == 0) hold_cycles = 3000;
			nv = $urandom_range(99);
			cfg = (nv < 30) ? 3'd1 : (nv < 60) ? 3'd2 : (nv < 85) ? 3'd3 :
				(nv < 93) ? 3'd4 : (nv < 96) ? 3'd5 : 3'($urandom_range(7, 6));
			if (cfg != sb.var_reg) begin
				drain();
				write_var_count(cfg);
			end
			eff = sb.vars_used();
			if ($urandom_range(99) < 85) begin
				len = 1 << eff;
			end else begin
				len = $urandom_range((1 << eff) + 3, 1);
			end
			send_run(len, $urandom_range(100, 40), 2);
		end
		drain();
		repeat (200) @(posedge clk);
		$display("%0d input words in %0d runs, %0d output words checked, counts 0..7",
			sent, sb.runs, sb.checked);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#50_000_000;
		$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
